/* rtl/vapm_pkg.sv */
package vapm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE_CONTROL    = 3'd0,
    REG_UNDERLINE_ROW   = 3'd1,
    REG_PLANE_ENABLE    = 3'd2,
    REG_PALETTE_LOW     = 3'd3,
    REG_PALETTE_HIGH    = 3'd4,
    REG_COLOR_SELECT    = 3'd5,
    REG_PALETTE_CONTROL = 3'd6,
    REG_PIXEL_MODE      = 3'd7
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int PAL_ENTRY_W = 6;
  localparam int PAL_BANK_W  = 48;

  // mode_control bits
  localparam int MC_MONO  = 1;
  localparam int MC_BLINK = 3;
  localparam int MC_C256  = 6;
  localparam int MC_USE54 = 7;

  // palette_control bits
  localparam int PC_ENABLE = 0;
  localparam int PC_BYPASS = 1;
  localparam int PC_CGA    = 2;

  // pixel_mode codes; anything else behaves as four-bit pixels
  localparam logic [1:0] PIX_MODE_4  = 2'd0;
  localparam logic [1:0] PIX_MODE_8  = 2'd1;
  localparam logic [1:0] PIX_MODE_16 = 2'd2;

  localparam logic [7:0] MONO_BLANK_MASK = 8'h88;
  localparam logic [2:0] UNDERLINE_ATTR  = 3'b001;

  localparam logic [7:0] RST_MODE_CONTROL    = 8'h00;
  localparam logic [4:0] RST_UNDERLINE_ROW   = 5'd0;
  localparam logic [3:0] RST_PLANE_ENABLE    = 4'hF;
  localparam logic [2:0] RST_PALETTE_CONTROL = 3'd1;

  typedef struct packed {
    logic [7:0]            mode_control;
    logic [4:0]            underline_row;
    logic [3:0]            plane_enable;
    logic [PAL_BANK_W-1:0] palette_low;
    logic [PAL_BANK_W-1:0] palette_high;
    logic [3:0]            color_select;
    logic [2:0]            palette_control;
    logic [1:0]            pixel_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] attribute;
    logic [4:0] char_row;
    logic       blink_phase;
    logic       pixel_on;
  } item_t;

  typedef struct packed {
    logic [15:0] dac_value;
    logic        pixel_ready;
    logic [1:0]  latch_phase;
  } result_t;

endpackage

/* rtl/vga_attribute_pixel_mapper.sv */
// An accepted input beat passes the input register, then the result register.
// Throughput: one pixel per cycle unless stalled; an input register and a result
// register bound the single pass of attribute, palette and latch logic.
// Reset (synchronous, active high): empties both stages, clears the nibble latches
// and phase, and loads the register defaults (plane enable 0xF, palette enabled).
module vga_attribute_pixel_mapper (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [vapm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vapm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [7:0]                       attribute,
  input  logic [4:0]                       char_row,
  input  logic                             blink_phase,
  input  logic                             pixel_on,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [15:0]                      dac_value,
  output logic                             pixel_ready,
  output logic [1:0]                       latch_phase
);
  import vapm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    out_free;
  logic    advance;
  logic [7:0] color;
  result_t latch_res, pix_res, result_q;

  vapm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1: input register. It refills whenever the result stage can move.
  assign out_free   = ~result_valid | ~result_stall;
  assign item_stall = item_q_valid & ~out_free;
  assign advance    = item_q_valid & out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= '{attribute: attribute, char_row: char_row,
                  blink_phase: blink_phase, pixel_on: pixel_on};
    end
  end

  // Colour selection, palette and colour-select / 256-colour handling
  vapm_map u_map (
    .item  (item_q),
    .cfg   (cfg),
    .color (color)
  );

  // Nibble latches for 8- and 16-bit pixels; state moves only with a beat
  vapm_latch u_latch (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .pixel_mode (cfg.pixel_mode),
    .nibble     (color[3:0]),
    .result     (latch_res)
  );

  // Four-bit mode (and the unused code) passes the mapped colour straight out
  always_comb begin
    pix_res = latch_res;
    if (cfg.pixel_mode != PIX_MODE_8 && cfg.pixel_mode != PIX_MODE_16) begin
      pix_res.dac_value = {8'b0, color};
    end
  end

  // Stage 2: result register, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= pix_res;
    end
  end

  assign dac_value   = result_q.dac_value;
  assign pixel_ready = result_q.pixel_ready;
  assign latch_phase = result_q.latch_phase;

  // Input only backs up when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while result stage could move");

  // A pixel is complete exactly when the nibble count has wrapped to zero
  a_ready_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pixel_ready == (latch_phase == 2'd0)))
    else $error("pixel_ready disagrees with latch_phase");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present after reset");

endmodule

/* rtl/vapm_cfg.sv */
module vapm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vapm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vapm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output vapm_pkg::cfg_t                     cfg
);
  import vapm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_control    <= RST_MODE_CONTROL;
      cfg.underline_row   <= RST_UNDERLINE_ROW;
      cfg.plane_enable    <= RST_PLANE_ENABLE;
      cfg.palette_low     <= '0;
      cfg.palette_high    <= '0;
      cfg.color_select    <= '0;
      cfg.palette_control <= RST_PALETTE_CONTROL;
      cfg.pixel_mode      <= PIX_MODE_4;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE_CONTROL:    cfg.mode_control    <= cfg_data[7:0];
        REG_UNDERLINE_ROW:   cfg.underline_row   <= cfg_data[4:0];
        REG_PLANE_ENABLE:    cfg.plane_enable    <= cfg_data[3:0];
        REG_PALETTE_LOW:     cfg.palette_low     <= cfg_data[PAL_BANK_W-1:0];
        REG_PALETTE_HIGH:    cfg.palette_high    <= cfg_data[PAL_BANK_W-1:0];
        REG_COLOR_SELECT:    cfg.color_select    <= cfg_data[3:0];
        REG_PALETTE_CONTROL: cfg.palette_control <= cfg_data[2:0];
        REG_PIXEL_MODE:      cfg.pixel_mode      <= cfg_data[1:0];
      endcase
    end
  end

endmodule

/* rtl/vapm_map.sv */
module vapm_map (
  input  vapm_pkg::item_t item,
  input  vapm_pkg::cfg_t  cfg,
  output logic [7:0]      color
);
  import vapm_pkg::*;

  logic                   mono, blink_en, c256, use54, pal_on, cga;
  logic                   fg;
  logic [3:0]             back, idx;
  logic [PAL_BANK_W-1:0]  bank;
  logic [PAL_ENTRY_W-1:0] entry;
  logic [1:0]             hi_bits;

  assign mono     = cfg.mode_control[MC_MONO];
  assign blink_en = cfg.mode_control[MC_BLINK];
  assign c256     = cfg.mode_control[MC_C256];
  assign use54    = cfg.mode_control[MC_USE54];
  assign pal_on   = cfg.palette_control[PC_ENABLE] & ~cfg.palette_control[PC_BYPASS];
  assign cga      = cfg.palette_control[PC_CGA];

  always_comb begin
    fg = item.pixel_on;
    if (mono) begin
      if (item.char_row == cfg.underline_row && item.attribute[2:0] == UNDERLINE_ATTR) begin
        fg = 1'b1;
      end
      // blanked attributes always show background
      if ((item.attribute & MONO_BLANK_MASK) == item.attribute) begin
        fg = 1'b0;
      end
    end
    if (blink_en && item.attribute[7]) begin
      fg = fg & item.blink_phase;
    end
  end

  // with blink on, attribute bit 7 is not part of the background colour
  assign back = item.attribute[7:4] & {~blink_en, 3'b111};
  assign idx  = (fg ? item.attribute[3:0] : back) & cfg.plane_enable;

  assign bank    = idx[3] ? cfg.palette_high : cfg.palette_low;
  assign entry   = bank[idx[2:0]*PAL_ENTRY_W +: PAL_ENTRY_W];
  assign hi_bits = use54 ? cfg.color_select[1:0] : entry[5:4];

  always_comb begin
    priority if (!pal_on) begin
      color = {4'b0, idx};
    end else if (cga) begin
      color = {2'b0, entry};
    end else if (c256) begin
      color = {4'b0, entry[3:0]};
    end else begin
      color = {cfg.color_select[3:2], hi_bits, entry[3:0]};
    end
  end

endmodule

/* rtl/vapm_latch.sv */
module vapm_latch (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [1:0]        pixel_mode,
  input  logic [3:0]        nibble,
  output vapm_pkg::result_t result
);
  import vapm_pkg::*;

  logic [7:0]  byte_latch, byte_latch_next;
  logic [15:0] word_latch, word_latch_next;
  logic [1:0]  nibble_phase, nibble_phase_next;

  always_comb begin
    byte_latch_next   = byte_latch;
    word_latch_next   = word_latch;
    nibble_phase_next = nibble_phase;
    unique case (pixel_mode)
      PIX_MODE_8: begin
        byte_latch_next   = {byte_latch[3:0], nibble};
        nibble_phase_next = {1'b0, ~nibble_phase[0]};
        result.dac_value  = {8'b0, byte_latch_next};
        result.pixel_ready = (nibble_phase_next == 2'd0);
        result.latch_phase = nibble_phase_next;
      end
      PIX_MODE_16: begin
        word_latch_next   = {word_latch[11:0], nibble};
        nibble_phase_next = nibble_phase + 2'd1;
        result.dac_value  = word_latch_next;
        result.pixel_ready = (nibble_phase_next == 2'd0);
        result.latch_phase = nibble_phase_next;
      end
      default: begin
        result.dac_value   = '0;
        result.pixel_ready = 1'b1;
        result.latch_phase = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_latch   <= '0;
      word_latch   <= '0;
      nibble_phase <= '0;
    end else if (advance) begin
      byte_latch   <= byte_latch_next;
      word_latch   <= word_latch_next;
      nibble_phase <= nibble_phase_next;
    end
  end

endmodule
